>>> sv/bus_telegram_escape_crc_encoder_core_macros.svh
// Assertion macros for the telegram escape and CRC encoder.
// Used by the top level; depends on a clock named clk and a reset named rst.
`ifndef BUS_TELEGRAM_ESCAPE_CRC_ENCODER_CORE_MACROS_SVH
`define BUS_TELEGRAM_ESCAPE_CRC_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BTEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BTEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/btec_pkg.sv
// Shared types, constants and the CRC-8 byte step for the telegram encoder.
// No dependencies; used by every module of the block.
package btec_pkg;

  // Result kinds carried with every output byte.
  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_DATA = 2'd1,
    KIND_CRC  = 2'd2
  } btec_kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SOURCE_ADDRESS = 2'd0,
    REG_SYNC_SYMBOL    = 2'd1,
    REG_ESCAPE_SYMBOL  = 2'd2
  } btec_reg_t;

  localparam logic [7:0] CRC_POLY     = 8'h9B;
  localparam logic [7:0] ESC_OF_SYNC  = 8'h01;
  localparam logic [7:0] ESC_OF_ESC   = 8'h00;
  localparam logic [7:0] SRC_ADDR_RST = 8'hFF;
  localparam logic [7:0] SYNC_RST     = 8'hAA;
  localparam logic [7:0] ESC_RST      = 8'hA9;

  // One item yields at most five result bytes.
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned IDX_W       = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } btec_item_t;

  typedef struct packed {
    logic [7:0] source_address;
    logic [7:0] sync_symbol;
    logic [7:0] escape_symbol;
  } btec_cfg_t;

  // All result bytes caused by one item, in emission order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data_bytes;
    logic [MAX_RESULTS-1:0][1:0] kinds;
    logic [IDX_W-1:0]            count;
    logic                        tel_end;
  } btec_group_t;

  // One CRC-8 step over a byte, data bits entering at the low end MSB first.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[7];
      c = {c[6:0], d[7]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> sv/btec_frame_builder.sv
// Builds the escaped result bytes for one input item and the CRC that follows it.
// Depends on btec_pkg.
module btec_frame_builder
  import btec_pkg::*;
(
  input  btec_item_t  item,
  input  btec_cfg_t   cfg,
  input  logic [7:0]  addr_crc,
  input  logic [7:0]  running_crc,
  input  logic        inside_frame,
  output btec_group_t grp,
  output logic [7:0]  crc_next,
  output logic        inside_next
);

  logic [IDX_W-1:0] k;
  logic [7:0]       crc;

  // Append the address at a telegram's start, the escaped data and, at the end of a telegram, the escaped CRC.
  always_comb begin
    grp = '0;
    k   = '0;
    crc = running_crc;

    if (!inside_frame) begin
      grp.data_bytes[k] = cfg.source_address;
      grp.kinds[k]      = KIND_ADDR;
      k   = k + 3'd1;
      crc = addr_crc;
    end

    // The data byte, escaped; every emitted data byte enters the CRC.
    if (item.data_byte == cfg.sync_symbol) begin
      grp.data_bytes[k]        = cfg.escape_symbol;
      grp.kinds[k]             = KIND_DATA;
      grp.data_bytes[k + 3'd1] = ESC_OF_SYNC;
      grp.kinds[k + 3'd1]      = KIND_DATA;
      k   = k + 3'd2;
      crc = crc_byte(crc_byte(crc, cfg.escape_symbol), ESC_OF_SYNC);
    end else if (item.data_byte == cfg.escape_symbol) begin
      grp.data_bytes[k]        = cfg.escape_symbol;
      grp.kinds[k]             = KIND_DATA;
      grp.data_bytes[k + 3'd1] = ESC_OF_ESC;
      grp.kinds[k + 3'd1]      = KIND_DATA;
      k   = k + 3'd2;
      crc = crc_byte(crc_byte(crc, cfg.escape_symbol), ESC_OF_ESC);
    end else begin
      grp.data_bytes[k] = item.data_byte;
      grp.kinds[k]      = KIND_DATA;
      k   = k + 3'd1;
      crc = crc_byte(crc, item.data_byte);
    end

    // The CRC trailer is escaped but not folded into the CRC.
    if (item.frame_end) begin
      if (crc == cfg.sync_symbol) begin
        grp.data_bytes[k]        = cfg.escape_symbol;
        grp.kinds[k]             = KIND_CRC;
        grp.data_bytes[k + 3'd1] = ESC_OF_SYNC;
        grp.kinds[k + 3'd1]      = KIND_CRC;
        k = k + 3'd2;
      end else if (crc == cfg.escape_symbol) begin
        grp.data_bytes[k]        = cfg.escape_symbol;
        grp.kinds[k]             = KIND_CRC;
        grp.data_bytes[k + 3'd1] = ESC_OF_ESC;
        grp.kinds[k + 3'd1]      = KIND_CRC;
        k = k + 3'd2;
      end else begin
        grp.data_bytes[k] = crc;
        grp.kinds[k]      = KIND_CRC;
        k = k + 3'd1;
      end
      crc_next    = 8'h00;
      inside_next = 1'b0;
    end else begin
      crc_next    = crc;
      inside_next = 1'b1;
    end

    grp.count   = k;
    grp.tel_end = item.frame_end;
  end

endmodule

>>> sv/btec_serializer.sv
// Holds one result group and sends its bytes out one transaction per cycle while m_tready is high.
// Depends on btec_pkg.
module btec_serializer
  import btec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  btec_group_t grp_in,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  btec_group_t      grp;
  logic             valid;
  logic [IDX_W-1:0] idx;
  logic             at_last;

  assign at_last  = (idx == grp.count - 3'd1);
  assign can_load = !valid || (m_tready && at_last);

  // Group register and byte pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && m_tready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  // Output fields of the current byte.
  assign m_tvalid = valid;
  assign m_tdata  = grp.data_bytes[idx];
  assign m_tuser  = {at_last, grp.kinds[idx]};
  assign m_tlast  = at_last && grp.tel_end;

endmodule

>>> sv/bus_telegram_escape_crc_encoder_core.sv
// Telegram escape and CRC-8 encoder, top level.
// Depends on btec_pkg, btec_frame_builder, btec_serializer and the macros header.
//
// Usage: each slave transaction carries one raw telegram data byte, with tlast
// on the final byte of the telegram. The first byte of a telegram is preceded
// by the source address. Data bytes equal to the sync or escape symbol leave as
// two bytes; after the final byte the CRC-8 (poly 0x9B) is appended, escaped.
// Master transactions carry one output byte each; tuser gives its kind and a
// flag on the last byte caused by the input item, tlast marks the CRC end.
// An accepted item waits in the input register, then enters the serializer's group
// register. Throughput: one output byte per cycle while m_tready is high; an item
// emits 1 to 5 bytes (1 for a plain data byte, 2 when escaped).
// The input register takes the next item while the current group drains, so
// tready falls only when both the input register and the output group are full.
// Configuration: cfg_we, cfg_index, cfg_wdata write one register per cycle;
// index 3 is ignored. Write only while the block is idle.
// Reset (synchronous rst): registers return to 0xFF/0xAA/0xA9, the CRC clears,
// and the next item starts a new telegram. A master stall holds the output
// byte and, once the input register fills, backpressures the slave side.
`include "bus_telegram_escape_crc_encoder_core_macros.svh"

module bus_telegram_escape_crc_encoder_core
  import btec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Configuration write port.
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // Slave side.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // frame_end
  // Master side.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [1:0] byte_kind, [2] run_last
  output logic       m_tlast    // telegram_last
);

  btec_cfg_t   cfg;
  logic [7:0]  addr_crc;
  logic [7:0]  running_crc;
  logic        inside_frame;
  logic        in_valid;
  btec_item_t  in_item;
  btec_group_t grp;
  logic [7:0]  crc_next;
  logic        inside_next;
  logic        can_load;
  logic        advance;

  // Configuration registers; the address CRC is kept ready for each telegram.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_address <= SRC_ADDR_RST;
      cfg.sync_symbol    <= SYNC_RST;
      cfg.escape_symbol  <= ESC_RST;
      addr_crc           <= crc_byte(8'h00, SRC_ADDR_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_ADDRESS: begin
          cfg.source_address <= cfg_wdata;
          addr_crc           <= crc_byte(8'h00, cfg_wdata);
        end
        REG_SYNC_SYMBOL:   cfg.sync_symbol   <= cfg_wdata;
        REG_ESCAPE_SYMBOL: cfg.escape_symbol <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte <= s_tdata;
      in_item.frame_end <= s_tlast;
    end
  end

  // Telegram state moves when an item's group enters the serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= 8'h00;
      inside_frame <= 1'b0;
    end else if (advance) begin
      running_crc  <= crc_next;
      inside_frame <= inside_next;
    end
  end

  btec_frame_builder u_builder (
    .item         (in_item),
    .cfg          (cfg),
    .addr_crc     (addr_crc),
    .running_crc  (running_crc),
    .inside_frame (inside_frame),
    .grp          (grp),
    .crc_next     (crc_next),
    .inside_next  (inside_next)
  );

  btec_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .grp_in   (grp),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks on the block's own sequencing.
  `BTEC_ASSERT_NOW(a_tlast_ends_run, m_tvalid && m_tlast, m_tuser[2], "telegram end not run end")
  `BTEC_ASSERT_NOW(a_tlast_is_crc, m_tvalid && m_tlast, m_tuser[1:0] == KIND_CRC, "tlast off CRC")
  `BTEC_ASSERT_NEXT(a_load_shows, advance, m_tvalid, "loaded group not presented")
  `BTEC_ASSERT_NEXT(a_hold_item, in_valid && !can_load, in_valid && $stable(in_item), "item lost")

endmodule

>>> dv/btec_encoder_checker.sv
// Checker for the telegram escape and CRC-8 encoder: predicts the escaped byte stream.
// Watches the configuration port and both stream channels; depends on btec_pkg.
module btec_encoder_checker
  import btec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // frame_end
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic [2:0] m_tuser,   // [1:0] byte_kind, [2] run_last
  input  logic       m_tlast,   // telegram_last
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    logic [7:0] out_byte;
    btec_kind_t byte_kind;
    logic       run_last;
    logic       telegram_last;
  } wire_byte_t;

  // Bytes still owed on the master side, oldest first.
  wire_byte_t expected_wire_bytes[$];
  // Bytes caused by the input transaction being predicted.
  wire_byte_t item_bytes[$];
  wire_byte_t got;
  wire_byte_t want;

  logic [7:0] src_addr;
  logic [7:0] sync_sym;
  logic [7:0] esc_sym;
  logic [7:0] crc_acc;
  logic       in_telegram;

  // CRC-8 with polynomial 0x9B: the data byte sits below the CRC in one shift
  // register, so its bits enter the CRC at the low end, MSB first.
  function automatic logic [7:0] crc9b_step(input logic [7:0] state, input logic [7:0] b);
    logic [15:0] sh;
    sh = {state, b};
    for (int i = 0; i < 8; i++) begin
      if (sh[15]) begin
        sh = {sh[14:0], 1'b0} ^ {CRC_POLY, 8'h00};
      end else begin
        sh = {sh[14:0], 1'b0};
      end
    end
    return sh[15:8];
  endfunction

  // Every byte that goes on the wire, except the CRC itself, feeds the CRC.
  function automatic void emit(input logic [7:0] b, input btec_kind_t k);
    item_bytes.push_back('{out_byte: b, byte_kind: k, run_last: 1'b0, telegram_last: 1'b0});
    if (k != KIND_CRC) begin
      crc_acc = crc9b_step(crc_acc, b);
    end
  endfunction

  // Sync wins over escape when both registers hold the same value.
  function automatic void emit_escaped(input logic [7:0] b, input btec_kind_t k);
    if (b == sync_sym) begin
      emit(esc_sym, k);
      emit(ESC_OF_SYNC, k);
    end else if (b == esc_sym) begin
      emit(esc_sym, k);
      emit(ESC_OF_ESC, k);
    end else begin
      emit(b, k);
    end
  endfunction

  // Works out the wire bytes for one accepted data byte.
  function automatic void encode_data_byte(input logic [7:0] d, input logic fin);
    wire_byte_t tail;
    item_bytes.delete();
    if (!in_telegram) begin
      emit(src_addr, KIND_ADDR);
      in_telegram = 1'b1;
    end
    emit_escaped(d, KIND_DATA);
    if (fin) begin
      emit_escaped(crc_acc, KIND_CRC);
      crc_acc     = '0;
      in_telegram = 1'b0;
    end
    tail = item_bytes.pop_back();
    tail.run_last      = 1'b1;
    tail.telegram_last = fin;
    item_bytes.push_back(tail);
    foreach (item_bytes[i]) begin
      expected_wire_bytes.push_back(item_bytes[i]);
    end
  endfunction

  // All sampling happens at the rising edge, on the values the block saw.
  always @(posedge clk) begin
    if (rst) begin
      src_addr    = SRC_ADDR_RST;
      sync_sym    = SYNC_RST;
      esc_sym     = ESC_RST;
      crc_acc     = '0;
      in_telegram = 1'b0;
      mismatches  = 0;
      expected_wire_bytes.delete();
    end else begin
      // Register writes; the unused index is ignored.
      if (cfg_we) begin
        case (btec_reg_t'(cfg_index))
          REG_SOURCE_ADDRESS: src_addr = cfg_wdata;
          REG_SYNC_SYMBOL:    sync_sym = cfg_wdata;
          REG_ESCAPE_SYMBOL:  esc_sym  = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        encode_data_byte(s_tdata, s_tlast);
      end
      // Compare each master transaction with the oldest expected byte.
      if (m_tvalid && m_tready) begin
        got = '{out_byte: m_tdata, byte_kind: btec_kind_t'(m_tuser[1:0]),
                run_last: m_tuser[2], telegram_last: m_tlast};
        if (expected_wire_bytes.size() == 0) begin
          $error("unexpected output byte %02h with no prediction waiting", m_tdata);
          mismatches++;
        end else begin
          want = expected_wire_bytes.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            mismatches++;
          end
          if (got.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, actual %0d", want.byte_kind, got.byte_kind);
            mismatches++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
            mismatches++;
          end
          if (got.telegram_last !== want.telegram_last) begin
            $error("telegram_last: expected %0b, actual %0b",
                   want.telegram_last, got.telegram_last);
            mismatches++;
          end
        end
      end
    end
    pending = expected_wire_bytes.size();
  end

endmodule

>>> dv/tb_bus_telegram_escape_crc_encoder_core.sv
// Testbench top for the telegram escape and CRC-8 encoder: clock, reset, stimulus, verdict.
// Depends on btec_pkg, the encoder core and btec_encoder_checker.
module tb_bus_telegram_escape_crc_encoder_core;
  import btec_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 400;
  localparam int         HOLD_CYCLES  = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  int mismatches;
  int pending;

  // Flags calm and hold_req are shared between the stimulus and the receiver process; hold_done is the receiver's own.
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // Register values as last written, for steering data toward special bytes.
  logic [7:0] cur_sync = SYNC_RST;
  logic [7:0] cur_esc = ESC_RST;

  bus_telegram_escape_crc_encoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  btec_encoder_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, one long hold-off on request, none while calm.
  initial begin : rx_ready_gen
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(99) < 27) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Generous fixed limit on the whole run.
  initial begin : watchdog
    #(12 * 300000);
    $display("tb_bus_telegram_escape_crc_encoder_core failed");
    $finish;
  end

  // One register write; the idle wait after it keeps write enable from being
  // lowered and raised in the same step.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (btec_reg_t'(idx))
      REG_SYNC_SYMBOL:    cur_sync = val;
      REG_ESCAPE_SYMBOL:  cur_esc  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one data byte, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted byte has left the block.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int         sent;
    int         phase_items;
    int         flen;
    logic [7:0] d;
    logic [7:0] crc_val;

    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Reset settings: field extremes and both special symbols as data.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(SYNC_RST, 1'b0);
    send_byte(ESC_RST, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();

    // Register extremes, plus a write to the unused index that must do nothing.
    cfg_write(REG_SOURCE_ADDRESS, 8'h00);
    cfg_write(REG_SYNC_SYMBOL, 8'hFF);
    cfg_write(REG_ESCAPE_SYMBOL, 8'h00);
    cfg_write(REG_UNUSED, 8'h5A);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // Sync and escape share a value: the sync translation applies.
    cfg_write(REG_SYNC_SYMBOL, 8'h3C);
    cfg_write(REG_ESCAPE_SYMBOL, 8'h3C);
    send_byte(8'h3C, 1'b1);
    drain();

    // Escaped data byte followed by a CRC that equals the sync symbol:
    // one item yields five bytes.
    cfg_write(REG_SOURCE_ADDRESS, 8'h12);
    cfg_write(REG_ESCAPE_SYMBOL, 8'h7D);
    crc_val = crc_byte(crc_byte(crc_byte(8'h00, 8'h12), 8'h7D), ESC_OF_ESC);
    cfg_write(REG_SYNC_SYMBOL, crc_val);
    send_byte(8'h7D, 1'b1);
    drain();

    // CRC that equals the escape symbol.
    crc_val = crc_byte(crc_byte(8'h00, 8'h12), 8'h21);
    cfg_write(REG_ESCAPE_SYMBOL, crc_val);
    send_byte(8'h21, 1'b1);
    drain();

    // Register change in the middle of a telegram.
    cfg_write(REG_SYNC_SYMBOL, 8'h10);
    cfg_write(REG_ESCAPE_SYMBOL, 8'h11);
    send_byte(8'h44, 1'b0);
    drain();
    cfg_write(REG_SYNC_SYMBOL, 8'h44);
    send_byte(8'h44, 1'b0);
    send_byte(8'h11, 1'b1);
    drain();

    // Random telegrams in phases, each with its own register settings.
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      drain();
      if (ph == 0) begin
        cfg_write(REG_SOURCE_ADDRESS, 8'hFF);
        cfg_write(REG_SYNC_SYMBOL, 8'h00);
        cfg_write(REG_ESCAPE_SYMBOL, 8'hFF);
      end else if (ph == 1) begin
        cfg_write(REG_SOURCE_ADDRESS, 8'h00);
        cfg_write(REG_SYNC_SYMBOL, 8'hFF);
        cfg_write(REG_ESCAPE_SYMBOL, 8'h00);
      end else begin
        cfg_write(REG_SOURCE_ADDRESS, 8'($urandom_range(255)));
        cfg_write(REG_SYNC_SYMBOL, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) begin
          cfg_write(REG_ESCAPE_SYMBOL, cur_sync);
        end else begin
          cfg_write(REG_ESCAPE_SYMBOL, 8'($urandom_range(255)));
        end
      end
      cfg_write(REG_UNUSED, 8'($urandom_range(255)));

      // The receiver holds off once while the sender keeps offering.
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      // A stretch with no idling on either side.
      calm = (ph == 3);

      phase_items = 0;
      while (phase_items < 50) begin
        flen = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(5, 1);
        for (int j = 0; j < flen; j++) begin
          case ($urandom_range(7))
            0: d = cur_sync;
            1: d = cur_esc;
            default: d = 8'($urandom_range(255));
          endcase
          send_byte(d, j == flen - 1);
          phase_items++;
          sent++;
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_bus_telegram_escape_crc_encoder_core passed");
    end else begin
      $display("tb_bus_telegram_escape_crc_encoder_core failed");
    end
    $finish;
  end

endmodule
